// File: sv/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; defines empty bodies when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define CDA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define CDA_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define CDA_ASSERT(lbl, clk, rst, prop)
`define CDA_NEVER(lbl, clk, rst, expr)

`endif

`endif

// File: sv/cda_pkg.sv
// types, codes and calendar helper functions for the date adder
// no dependencies
package cda_pkg;

  // operation codes carried by func
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_DAYS   = 2'd1;
  localparam logic [1:0] FUNC_MONTHS = 2'd2;
  localparam logic [1:0] FUNC_YEARS  = 2'd3;

  // shared divider geometry: quotient is (dividend * reciprocal) >> 26, exact
  // for any 17-bit dividend with these rounded-up reciprocals of 12 and 400
  localparam int unsigned DIV_W    = 17;
  localparam logic [22:0] RCP_MON  = 23'd5592406;
  localparam logic [22:0] RCP_YEAR = 23'd167773;

  // month index bias keeps the dividend positive: 12 * 4096 - 1
  localparam logic [DIV_W-1:0] MON_BIAS = 17'd49151;
  localparam logic [15:0]      Q_BIAS   = 16'd4096;

  // 32768 mod 400 correction for the offset-binary year
  localparam logic [9:0] R400_ADJ  = 10'd32;
  localparam logic [9:0] R400_MOD  = 10'd400;
  localparam logic [8:0] YEAR_DIV  = 9'd400;
  localparam logic [8:0] MON_DIV   = 9'd12;

  localparam logic [15:0] YEAR_BAD = 16'h8000;

  typedef struct packed {
    logic accept;
    logic div_year_load;
    logic div_step;
    logic mon_set;
    logic year_set;
    logic walk;
    logic clamp;
    logic sum;
    logic wday;
  } cmd_t;

  typedef struct packed {
    logic cur_ok;
    logic div_last;
    logic cnt_zero;
    logic year_cross;
  } stat_t;

  function automatic logic [4:0] month_len(input logic [7:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      8'd2: len = leap ? 5'd29 : 5'd28;
      8'd4, 8'd6, 8'd9, 8'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // leap year from the floor remainder of the year by 400
  function automatic logic leap_of(input logic [8:0] r400);
    return (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200) &&
           (r400 != 9'd300);
  endfunction

  // day of a march-based year on which the month starts
  function automatic logic [8:0] doy_of(input logic [7:0] m);
    logic [8:0] d;
    unique case (m)
      8'd3:  d = 9'd0;
      8'd4:  d = 9'd31;
      8'd5:  d = 9'd61;
      8'd6:  d = 9'd92;
      8'd7:  d = 9'd122;
      8'd8:  d = 9'd153;
      8'd9:  d = 9'd184;
      8'd10: d = 9'd214;
      8'd11: d = 9'd245;
      8'd12: d = 9'd275;
      8'd1:  d = 9'd306;
      8'd2:  d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: sv/calendar_date_adder_unit.sv
// top level of the gregorian date adder: controller, datapath, checks
// depends on cda_pkg, cda_ctrl, cda_dpath (which holds cda_div), assert_macros.svh
//
// The unit holds one date (signed year, month, day), which may be invalid; reset
// leaves year 0, month 0, day 0. A word is taken at a clock edge where start is
// high and busy is low; func picks load, add days, add months or add years. Every
// word gives exactly one result, shown for one cycle with done high; the receiver
// must take it then, since the unit has no way to hold it. busy stays high from
// the accepting edge through the done cycle, so the next word can be taken on the
// edge after done drops. What each operation does after the accepting edge:
//   load or add years: a two-step divide of the year by 400 for its leap
//     and weekday remainder
//   add months: two-step divide of the month index by 12, then the divide
//     by 400
//   add days to an invalid date: the amount is added straight onto the day
//   add days to a valid date: the day walk moves one day per cycle, pausing
//     after each year boundary while the divider recomputes the year's
//     remainder by 400
// The divider works by reciprocal multiplication and is shared by the month
// split and the leap/weekday remainder, so the walk of days is what sets the
// long cases.
`include "assert_macros.svh"

module calendar_date_adder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [15:0] load_year,
  input  logic [7:0]         load_month,
  input  logic [7:0]         load_day,
  input  logic signed [15:0] amount,
  output logic               done,
  output logic signed [15:0] year_now,
  output logic [7:0]         month_now,
  output logic [7:0]         day_now,
  output logic               date_ok,
  output logic [2:0]         week_day
);

  // command and status between sequencer and datapath
  cda_pkg::cmd_t  cmd;
  cda_pkg::stat_t stat;

  // sequencer: one state per phase of an operation
  cda_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: date registers, day stepper, shared divider, weekday stages
  cda_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .func       (func),
    .load_year  (load_year),
    .load_month (load_month),
    .load_day   (load_day),
    .amount     (amount),
    .year_now   (year_now),
    .month_now  (month_now),
    .day_now    (day_now),
    .date_ok    (date_ok),
    .week_day   (week_day)
  );

  // result strobe only while an operation is in flight, then the unit frees up
  `CDA_ASSERT(a_done_busy, clk, rst, done |-> busy)
  `CDA_ASSERT(a_done_release, clk, rst, done |=> !busy)
  // weekday is zero exactly when the month is out of range
  `CDA_ASSERT(a_wday_month, clk, rst,
    done |-> ((week_day == 3'd0) == (month_now == 8'd0 || month_now > 8'd12)))
  // a valid date never reports day zero
  `CDA_NEVER(a_ok_day_zero, clk, rst, done && date_ok && day_now == 8'd0)

endmodule

// File: sv/cda_div.sv
// divider by 12 or 400: reciprocal multiply for the quotient, then the remainder
// depends on cda_pkg
module cda_div (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic                        sel_year,
  input  logic [cda_pkg::DIV_W-1:0]   dividend,
  output logic [cda_pkg::DIV_W-1:0]   quot,
  output logic [8:0]                  rem,
  output logic                        last
);

  logic [cda_pkg::DIV_W-1:0] num;
  logic [8:0]                dsr;
  logic [22:0]               rcp;
  logic [cda_pkg::DIV_W-1:0] quo;
  logic [8:0]                part;
  logic                      q_ready;
  logic [39:0]               prod;
  logic [25:0]               qd;
  logic [cda_pkg::DIV_W-1:0] diff;

  // first step takes the quotient from the product, second the remainder
  assign prod = {23'd0, num} * {17'd0, rcp};
  assign qd   = {9'd0, quo} * {17'd0, dsr};
  assign diff = num - qd[16:0];

  always_ff @(posedge clk) begin
    if (load) begin
      num     <= dividend;
      dsr     <= sel_year ? cda_pkg::YEAR_DIV : cda_pkg::MON_DIV;
      rcp     <= sel_year ? cda_pkg::RCP_YEAR : cda_pkg::RCP_MON;
      q_ready <= 1'b0;
    end else if (step) begin
      if (!q_ready) begin
        quo     <= {3'd0, prod[39:26]};
        q_ready <= 1'b1;
      end else begin
        part <= diff[8:0];
      end
    end
  end

  assign quot = quo;
  assign rem  = part;
  assign last = q_ready;

endmodule

// File: sv/cda_ctrl.sv
// sequencer for the date adder: issues datapath commands per state
// depends on cda_pkg
module cda_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       func,
  input  cda_pkg::stat_t   stat,
  output cda_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [3:0] {
    S_IDLE, S_MDIV, S_MSET, S_YSTART, S_YDIV, S_YSET,
    S_CLAMP, S_WALK, S_SUM, S_WDAY, S_OUT
  } state_t;

  state_t state, state_next;
  logic   ret_walk, ret_walk_next;

  always_comb begin
    state_next    = state;
    ret_walk_next = ret_walk;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept    = 1'b1;
          ret_walk_next = 1'b0;
          unique case (func)
            cda_pkg::FUNC_LOAD:   state_next = S_YSTART;
            cda_pkg::FUNC_DAYS:   state_next = stat.cur_ok ? S_WALK : S_SUM;
            cda_pkg::FUNC_MONTHS: state_next = S_MDIV;
            cda_pkg::FUNC_YEARS:  state_next = S_YSTART;
          endcase
        end
      end
      S_MDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_MSET;
      end
      S_MSET: begin
        cmd.mon_set = 1'b1;
        state_next  = S_YSTART;
      end
      S_YSTART: begin
        cmd.div_year_load = 1'b1;
        state_next        = S_YDIV;
      end
      S_YDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_YSET;
      end
      S_YSET: begin
        cmd.year_set = 1'b1;
        state_next   = ret_walk ? S_WALK : S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_SUM;
      end
      S_WALK: begin
        if (stat.cnt_zero) begin
          state_next = S_SUM;
        end else begin
          cmd.walk = 1'b1;
          if (stat.year_cross) begin
            state_next    = S_YSTART;
            ret_walk_next = 1'b1;
          end
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_WDAY;
      end
      S_WDAY: begin
        cmd.wday   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret_walk <= 1'b0;
      busy     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      ret_walk <= ret_walk_next;
      busy     <= (state_next != S_IDLE);
      done     <= (state_next == S_OUT);
    end
  end

endmodule

// File: sv/cda_dpath.sv
// date registers, day stepper, month/year update and weekday logic
// depends on cda_pkg and cda_div
module cda_dpath (
  input  logic               clk,
  input  logic               rst,
  input  cda_pkg::cmd_t      cmd,
  output cda_pkg::stat_t     stat,
  input  logic [1:0]         func,
  input  logic signed [15:0] load_year,
  input  logic [7:0]         load_month,
  input  logic [7:0]         load_day,
  input  logic signed [15:0] amount,
  output logic signed [15:0] year_now,
  output logic [7:0]         month_now,
  output logic [7:0]         day_now,
  output logic               date_ok,
  output logic [2:0]         week_day
);

  logic [15:0] year;
  logic [7:0]  month, day;
  logic [8:0]  r400;
  logic [15:0] cnt;
  logic        back, clamp_en, mon_ok;
  logic [10:0] wsum;

  logic                       leap, year_ok, month_ok;
  logic [4:0]                 len_cur, len_prev;
  logic [7:0]                 day_inc, day_dec, mon_prev, mon_nxt;
  logic                       fwd_ok, bwd_ok;
  logic                       div_load;
  logic [cda_pkg::DIV_W-1:0]  dividend, quot;
  logic [8:0]                 rem;
  logic                       div_last;
  logic [9:0]                 rsum;
  logic [8:0]                 yoe;
  logic [1:0]                 cent;
  logic [10:0]                s_all;
  logic [4:0]                 fold1;
  logic [3:0]                 fold2;
  logic [2:0]                 wmod;

  assign leap     = cda_pkg::leap_of(r400);
  assign year_ok  = (year != cda_pkg::YEAR_BAD);
  assign month_ok = (month >= 8'd1) && (month <= 8'd12);
  assign len_cur  = cda_pkg::month_len(month, leap);
  assign mon_prev = (month == 8'd1) ? 8'd12 : month - 8'd1;
  assign mon_nxt  = (month == 8'd12) ? 8'd1 : month + 8'd1;
  assign len_prev = cda_pkg::month_len(mon_prev, leap);
  assign day_inc  = day + 8'd1;
  assign day_dec  = day - 8'd1;
  assign fwd_ok   = year_ok && (day_inc != 8'd0) && (day_inc <= {3'd0, len_cur});
  assign bwd_ok   = year_ok && (day_dec != 8'd0) && (day_dec <= {3'd0, len_cur});

  assign stat.cur_ok     = year_ok && month_ok && (day != 8'd0) &&
                           (day <= {3'd0, len_cur});
  assign stat.cnt_zero   = (cnt == 16'd0);
  assign stat.year_cross = back ? (!bwd_ok && month == 8'd1) :
                                  (!fwd_ok && month == 8'd12);
  assign stat.div_last   = div_last;

  // months path divides the biased month index, otherwise the offset-binary year
  assign div_load = (cmd.accept && func == cda_pkg::FUNC_MONTHS) || cmd.div_year_load;
  assign dividend = cmd.div_year_load ? {1'b0, ~year[15], year[14:0]} :
                    17'(17'(month) + {amount[15], amount} + cda_pkg::MON_BIAS);

  cda_div u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (cmd.div_step),
    .sel_year (cmd.div_year_load),
    .dividend (dividend),
    .quot     (quot),
    .rem      (rem),
    .last     (div_last)
  );

  assign rsum = {1'b0, rem} + cda_pkg::R400_ADJ;

  // weekday: days since a march-based era, mod 7
  always_comb begin
    if (month <= 8'd2) begin
      yoe = (r400 == 9'd0) ? 9'd399 : r400 - 9'd1;
    end else begin
      yoe = r400;
    end
    if (yoe >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    s_all = 11'(yoe) + 11'(yoe[8:2]) - 11'(cent) + 11'(cda_pkg::doy_of(month)) +
            11'(day) + 11'd9;
  end

  // 8 is 1 mod 7, so octal digits sum to the same residue
  assign fold1 = 5'(wsum[2:0]) + 5'(wsum[5:3]) + 5'(wsum[8:6]) + 5'(wsum[10:9]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
  assign wmod  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= '0;
      month <= '0;
      day   <= '0;
      r400  <= '0;
    end else begin
      if (cmd.accept) begin
        unique case (func)
          cda_pkg::FUNC_LOAD: begin
            year  <= load_year;
            month <= load_month;
            day   <= load_day;
          end
          cda_pkg::FUNC_DAYS: begin
            if (!stat.cur_ok) day <= day + amount[7:0];
          end
          cda_pkg::FUNC_MONTHS: ;
          cda_pkg::FUNC_YEARS: year <= year + amount;
        endcase
      end
      if (cmd.mon_set) begin
        month <= 8'(rem) + 8'd1;
        year  <= year + (quot[15:0] - cda_pkg::Q_BIAS);
      end
      if (cmd.year_set) begin
        r400 <= (rsum >= cda_pkg::R400_MOD) ? 9'(rsum - cda_pkg::R400_MOD) : rsum[8:0];
      end
      if (cmd.clamp && clamp_en && day > {3'd0, len_cur}) begin
        day <= {3'd0, len_cur};
      end
      if (cmd.walk) begin
        if (back) begin
          if (bwd_ok) begin
            day <= day_dec;
          end else begin
            month <= mon_prev;
            day   <= {3'd0, len_prev};
            if (month == 8'd1) year <= year - 16'd1;
          end
        end else begin
          if (fwd_ok) begin
            day <= day_inc;
          end else begin
            month <= mon_nxt;
            day   <= 8'd1;
            if (month == 8'd12) year <= year + 16'd1;
          end
        end
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      back     <= amount[15];
      cnt      <= amount[15] ? (~amount + 16'd1) : amount;
      clamp_en <= stat.cur_ok &&
                  (func == cda_pkg::FUNC_MONTHS || func == cda_pkg::FUNC_YEARS);
    end else if (cmd.walk) begin
      cnt <= cnt - 16'd1;
    end
    if (cmd.sum) begin
      wsum    <= s_all;
      mon_ok  <= month_ok;
      date_ok <= stat.cur_ok;
    end
    if (cmd.wday) begin
      week_day <= mon_ok ? wmod + 3'd1 : 3'd0;
    end
  end

  assign year_now  = year;
  assign month_now = month;
  assign day_now   = day;

endmodule

// File: tb/calendar_date_adder_unit_test.sv
// self-checking testbench for calendar_date_adder_unit: directed and random date words
// depends on cda_pkg (operation codes) and the calendar_date_adder_unit rtl
module calendar_date_adder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected result word
  typedef struct {
    logic signed [15:0] year;
    logic [7:0]         month;
    logic [7:0]         day;
    logic               ok;
    logic [2:0]         wday;
  } date_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         func;
  logic signed [15:0] load_year;
  logic [7:0]         load_month;
  logic [7:0]         load_day;
  logic signed [15:0] amount;
  logic               done;
  logic signed [15:0] year_now;
  logic [7:0]         month_now;
  logic [7:0]         day_now;
  logic               date_ok;
  logic [2:0]         week_day;

  // predicted date held by the unit, kept in plain ints
  int held_year  = 0;
  int held_month = 0;
  int held_day   = 0;

  date_result_t expected_dates[$];
  int mismatch_count = 0;

  calendar_date_adder_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .load_year  (load_year),
    .load_month (load_month),
    .load_day   (load_day),
    .amount     (amount),
    .done       (done),
    .year_now   (year_now),
    .month_now  (month_now),
    .day_now    (day_now),
    .date_ok    (date_ok),
    .week_day   (week_day)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // calendar predictor
  // ---------------------------------------------------------------------

  // 16-bit two's complement wrap of the year
  function automatic int wrap_year(input int v);
    int w;
    w = v & 32'hFFFF;
    return (w >= 32768) ? w - 65536 : w;
  endfunction

  function automatic bit is_leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_days(input int y, input int m);
    if (m == 2) return is_leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // year -32768 never counts as a valid year
  function automatic bit held_date_ok();
    if (held_year == -32768 || held_month < 1 || held_month > 12) return 1'b0;
    return (held_day >= 1) && (held_day <= month_days(held_year, held_month));
  endfunction

  // month index split by floor division, so month 0 reads as one before january
  function automatic void roll_months(input int n);
    int t;
    int q;
    t = held_month - 1 + n;
    q = (t >= 0) ? t / 12 : -((11 - t) / 12);
    held_month = t - q * 12 + 1;
    held_year  = wrap_year(held_year + q);
  endfunction

  function automatic void pull_day_in();
    int len;
    len = month_days(held_year, held_month);
    if (held_day > len) held_day = len;
  endfunction

  // invalid date: plain modulo-256 add; valid date: walk day by day
  function automatic void walk_days(input int n);
    if (!held_date_ok()) begin
      held_day = (held_day + n) & 255;
      return;
    end
    while (n > 0) begin
      held_day = (held_day + 1) & 255;
      if (!held_date_ok()) begin
        roll_months(1);
        held_day = 1;
      end
      n--;
    end
    while (n < 0) begin
      held_day = (held_day - 1) & 255;
      if (!held_date_ok()) begin
        // borrow lands on the last day, even in year -32768
        roll_months(-1);
        held_day = month_days(held_year, held_month);
      end
      n++;
    end
  endfunction

  // day count from a march-based era, then offset so 1 is sunday
  function automatic logic [2:0] weekday_now();
    int y, m, era, yoe, doy, doe, z, w;
    if (held_month < 1 || held_month > 12) return 3'd0;
    m   = held_month;
    y   = held_year - ((m <= 2) ? 1 : 0);
    era = ((y >= 0) ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    z   = era * 146097 + doe - 719468;
    z   = z + 4 + (held_day - 1);
    w   = ((z % 7) + 7) % 7;
    return 3'(w + 1);
  endfunction

  // apply one accepted word to the held date and queue its result
  function automatic void predict_word(input logic [1:0] f, input logic signed [15:0] ly,
                                       input logic [7:0] lm, input logic [7:0] ld,
                                       input logic signed [15:0] amt);
    date_result_t r;
    bit was_ok;
    int n;
    n = amt;
    case (f)
      cda_pkg::FUNC_LOAD: begin
        held_year  = ly;
        held_month = lm;
        held_day   = ld;
      end
      cda_pkg::FUNC_DAYS: begin
        walk_days(n);
      end
      cda_pkg::FUNC_MONTHS: begin
        was_ok = held_date_ok();
        roll_months(n);
        if (was_ok && !held_date_ok()) pull_day_in();
      end
      default: begin
        was_ok = held_date_ok();
        held_year = wrap_year(held_year + n);
        if (was_ok && !held_date_ok()) pull_day_in();
      end
    endcase
    r.year  = held_year[15:0];
    r.month = held_month[7:0];
    r.day   = held_day[7:0];
    r.ok    = held_date_ok();
    r.wday  = weekday_now();
    expected_dates.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40)
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // done lasts one cycle and cannot be held off, so every done edge is a result
  always @(posedge clk) begin
    date_result_t w;
    if (!rst && done !== 1'b0) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("unexpected result word", int'(year_now), 0);
      end else begin
        w = expected_dates.pop_front();
        if (year_now !== w.year)   report_mismatch("year_now", year_now, w.year);
        if (month_now !== w.month) report_mismatch("month_now", month_now, w.month);
        if (day_now !== w.day)     report_mismatch("day_now", day_now, w.day);
        if (date_ok !== w.ok)      report_mismatch("date_ok", date_ok, w.ok);
        if (week_day !== w.wday)   report_mismatch("week_day", week_day, w.wday);
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  // start stays high across back-to-back words; only gaps lower it
  task automatic send_word(input logic [1:0] f, input logic signed [15:0] ly,
                           input logic [7:0] lm, input logic [7:0] ld,
                           input logic signed [15:0] amt);
    func       <= f;
    load_year  <= ly;
    load_month <= lm;
    load_day   <= ld;
    amount     <= amt;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(f, ly, lm, ld, amt);
  endtask

  task automatic send_load(input int y, input int m, input int d);
    send_word(cda_pkg::FUNC_LOAD, y[15:0], m[7:0], d[7:0], 16'($urandom));
  endtask

  // unused load fields get random bits so they toggle under every operation
  task automatic send_op(input logic [1:0] f, input int amt);
    send_word(f, 16'($urandom), 8'($urandom), 8'($urandom), amt[15:0]);
  endtask

  // random idle cycles between words, gap_pct chance per cycle
  task automatic sender_gap(input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic int pick_year();
    int s;
    s = $urandom_range(99);
    if (s < 50) return int'($urandom_range(5000)) - 2500;
    if (s < 70) return int'($urandom_range(2100, 1582));
    if (s < 85) return int'($urandom_range(65535)) - 32768;
    if (s < 92) return 32767 - int'($urandom_range(2));
    return -32767 + int'($urandom_range(2));
  endfunction

  // full-size day walks are slow, so they stay rare
  function automatic int pick_day_count();
    int s;
    s = $urandom_range(99);
    if (s < 40) return int'($urandom_range(80)) - 40;
    if (s < 85) return int'($urandom_range(800)) - 400;
    if (s < 99) return int'($urandom_range(6000)) - 3000;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int pick_span(input int near, input int wide);
    int s;
    s = $urandom_range(99);
    if (s < 50) return int'($urandom_range(2 * near)) - near;
    if (s < 80) return int'($urandom_range(2 * wide)) - wide;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // valid date, with the day often at the month end to hit the clamp
  task automatic send_valid_load();
    int y, m, d, len;
    y   = pick_year();
    if (y == -32768) y = 2000;
    m   = $urandom_range(12, 1);
    len = month_days(y, m);
    if ($urandom_range(1)) d = $urandom_range(len, 1);
    else d = len - int'($urandom_range(2));
    send_load(y, m, d);
  endtask

  task automatic send_random_word();
    int r;
    r = $urandom_range(99);
    if (r < 10)      send_valid_load();
    else if (r < 14) send_word(cda_pkg::FUNC_LOAD, 16'($urandom), 8'($urandom),
                               8'($urandom), 16'($urandom));
    else if (r < 56) send_op(cda_pkg::FUNC_DAYS, pick_day_count());
    else if (r < 78) send_op(cda_pkg::FUNC_MONTHS, pick_span(30, 1200));
    else             send_op(cda_pkg::FUNC_YEARS, pick_span(10, 3000));
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  task automatic test_directed();
    // reset date is invalid: days add straight onto day, weekday reads 0
    send_op(cda_pkg::FUNC_DAYS, 5);
    // month 0 counts as one before january
    send_op(cda_pkg::FUNC_MONTHS, 1);
    // forward step out of the last year wraps into year -32768
    send_load(32767, 12, 31);
    send_op(cda_pkg::FUNC_DAYS, 1);
    send_op(cda_pkg::FUNC_DAYS, 1);
    // backward step borrows into a month of year -32768
    send_load(-32767, 1, 1);
    send_op(cda_pkg::FUNC_DAYS, -1);
    // month add clamps to a leap february, year add clamps it again
    send_load(2024, 1, 31);
    send_op(cda_pkg::FUNC_MONTHS, 1);
    send_op(cda_pkg::FUNC_YEARS, 1);
    // century years: 1900 is not leap, 2000 is
    send_load(1900, 2, 28);
    send_op(cda_pkg::FUNC_DAYS, 1);
    send_load(2000, 3, 1);
    send_op(cda_pkg::FUNC_DAYS, -1);
    // extreme month and year amounts
    send_op(cda_pkg::FUNC_MONTHS, 32767);
    send_op(cda_pkg::FUNC_MONTHS, -32768);
    send_load(2020, 6, 15);
    send_op(cda_pkg::FUNC_YEARS, 32767);
    send_op(cda_pkg::FUNC_YEARS, -32768);
    // raw extremes of the load fields, then modulo-256 day add
    send_word(cda_pkg::FUNC_LOAD, 16'h8000, 8'hFF, 8'hFF, 16'h0000);
    send_op(cda_pkg::FUNC_DAYS, -32768);
    send_load(-1, 13, 250);
    send_op(cda_pkg::FUNC_DAYS, 10);
    // longest day walks in both directions
    send_load(2000, 1, 1);
    send_op(cda_pkg::FUNC_DAYS, 32767);
    send_op(cda_pkg::FUNC_DAYS, -32768);
  endtask

  task automatic test_random_phase(input int n_words, input int gap_pct);
    repeat (n_words) begin
      sender_gap(gap_pct);
      send_random_word();
    end
  endtask

  // sender waits for every pending result before each burst
  task automatic test_drain_pause();
    repeat (6) begin
      start <= 1'b0;
      do @(posedge clk); while (expected_dates.size() != 0);
      send_valid_load();
      repeat ($urandom_range(4, 1)) send_random_word();
    end
  endtask

  initial begin
    start      = 1'b0;
    func       = cda_pkg::FUNC_LOAD;
    load_year  = '0;
    load_month = '0;
    load_day   = '0;
    amount     = '0;
    rst        = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    // the receiver cannot stall, so phases differ only in sender gaps
    test_random_phase(260, 0);
    test_random_phase(260, 49);
    test_drain_pause();
    test_random_phase(250, 34);

    start <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/cda_pkg.sv
sv/cda_div.sv
sv/cda_ctrl.sv
sv/cda_dpath.sv
sv/calendar_date_adder_unit.sv
tb/calendar_date_adder_unit_test.sv
